// File: rtl/srctl_pkg.sv
// ----------------------------------------------------------------------------
// srctl_pkg
// Shared types and constants for the stepper ramp controller: field widths,
// event kinds, register indexes, ramp phases and the divider interface.
// ----------------------------------------------------------------------------
`default_nettype none

package srctl_pkg;

    localparam int KIND_W   = 3;
    localparam int POS_W    = 32;
    localparam int PERIOD_W = 20;
    localparam int SPEED_W  = 10;
    localparam int BASE_W   = 16;
    localparam int FDIV_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int DIV_STEPS = PERIOD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [PERIOD_W-1:0] RAMP_NUMERATOR = PERIOD_W'(512);
    localparam logic [SPEED_W-1:0]  SPEED_STEP     = SPEED_W'(1);
    localparam logic [SPEED_W-1:0]  SPEED_LIMIT    = SPEED_W'(513);

    localparam logic [BASE_W-1:0] BASE_PERIOD_RST  = BASE_W'(10);
    localparam logic [FDIV_W-1:0] FAST_DIVISOR_RST = FDIV_W'(8);

    localparam logic [KIND_W-1:0] KIND_TICK     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_STEP     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_START    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STOP     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TSTOPPED = 3'd4;
    localparam logic [KIND_W-1:0] KIND_LOAD     = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_PERIOD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_DIVISOR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GOTO_MODE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_SPEED    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_DIR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_POSITION = 3'd5;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ACCEL  = 2'd1,
        PH_CRUISE = 2'd2,
        PH_DECEL  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_DONE = 2'd2
    } state_t;

    typedef enum logic [1:0] {
        OP_ACCEL  = 2'd0,
        OP_DECEL  = 2'd1,
        OP_CRUISE = 2'd2
    } div_op_t;

    typedef struct packed {
        logic                start;
        logic [PERIOD_W-1:0] dividend;
        logic [SPEED_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [PERIOD_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/srctl_div.sv
// ----------------------------------------------------------------------------
// srctl_div
// Restoring divider that produces one quotient bit per cycle. A request loads
// the operands; the quotient is valid when done pulses.
// ----------------------------------------------------------------------------
`default_nettype none

module srctl_div
    import srctl_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [PERIOD_W-1:0]  quo_reg, quo_next;
    logic [SPEED_W-1:0]   rem_reg, rem_next;
    logic [SPEED_W-1:0]   dvs_reg, dvs_next;
    logic [SPEED_W:0]     shifted;
    logic [SPEED_W:0]     diff;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        shifted   = {rem_reg, quo_reg[PERIOD_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS - 1);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, dvs_reg}) begin
                rem_next = diff[SPEED_W-1:0];
                quo_next = {quo_reg[PERIOD_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[SPEED_W-1:0];
                quo_next = {quo_reg[PERIOD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// File: rtl/stepper_ramp_controller_core.sv
// Sequencing: a tick in accel, a tick in decel above SPEED_STEP, or a
// fast-mode start that divides the cruise period waits in the divide state
// for the bit-serial divider before its result is registered; every other
// event goes straight to the done state. A new request is taken only in idle,
// so not before the previous one is through. A result may wait in the output
// register while the next request is taken. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
// stepper_ramp_controller_core
// Trapezoidal ramp controller for one stepper axis. Each request may update the
// ramp phase, speed, cruise period or step position and returns one result.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_ramp_controller_core
    import srctl_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [KIND_W-1:0]     s_kind,
    input  wire logic [POS_W-1:0]      s_load_value,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_period_write,
    output logic [PERIOD_W-1:0]        m_period_value,
    output logic                       m_timer_start,
    output logic                       m_timer_stop,
    output logic                       m_dir_level,
    output logic                       m_busy_res,
    output logic [POS_W-1:0]           m_position,
    output logic [1:0]                 m_phase
);

    logic [BASE_W-1:0]   base_period_reg;
    logic [FDIV_W-1:0]   fast_divisor_reg;
    logic                goto_mode_reg;
    logic                fast_speed_reg;
    logic                reverse_dir_reg;
    logic [POS_W-1:0]    goal_position_reg;

    state_t              state_reg, state_next;
    div_op_t             op_reg, op_next;
    phase_t              phase_reg, phase_next;
    logic [SPEED_W-1:0]  speed_reg, speed_next;
    logic [PERIOD_W-1:0] cruise_reg, cruise_next;
    logic [POS_W-1:0]    position_reg, position_next;

    logic                res_pw_reg, res_pw_next;
    logic [PERIOD_W-1:0] res_pv_reg, res_pv_next;
    logic                res_tstart_reg, res_tstart_next;
    logic                res_tstop_reg, res_tstop_next;

    logic                m_valid_reg, m_valid_next;
    logic                out_load;

    logic                accept;
    logic [SPEED_W-1:0]  speed_inc;
    logic [SPEED_W-1:0]  speed_dec;
    logic [POS_W-1:0]    pos_stepped;
    logic [PERIOD_W-1:0] cruise_full;

    div_req_t            div_req;
    div_rsp_t            div_rsp;

    srctl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_period_reg   <= BASE_PERIOD_RST;
            fast_divisor_reg  <= FAST_DIVISOR_RST;
            goto_mode_reg     <= 1'b0;
            fast_speed_reg    <= 1'b0;
            reverse_dir_reg   <= 1'b0;
            goal_position_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_BASE_PERIOD:   base_period_reg   <= cfg_data[BASE_W-1:0];
                REG_FAST_DIVISOR:  fast_divisor_reg  <= cfg_data[FDIV_W-1:0];
                REG_GOTO_MODE:     goto_mode_reg     <= cfg_data[0];
                REG_FAST_SPEED:    fast_speed_reg    <= cfg_data[0];
                REG_REVERSE_DIR:   reverse_dir_reg   <= cfg_data[0];
                REG_GOAL_POSITION: goal_position_reg <= cfg_data[POS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign speed_inc   = speed_reg + SPEED_STEP;
    assign speed_dec   = speed_reg - SPEED_STEP;
    assign pos_stepped = reverse_dir_reg ? (position_reg - POS_W'(1))
                                         : (position_reg + POS_W'(1));
    assign cruise_full = {1'b0, base_period_reg, 3'b000}
                       + {3'b000, base_period_reg, 1'b0};

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        phase_next      = phase_reg;
        speed_next      = speed_reg;
        cruise_next     = cruise_reg;
        position_next   = position_reg;
        res_pw_next     = res_pw_reg;
        res_pv_next     = res_pv_reg;
        res_tstart_next = res_tstart_reg;
        res_tstop_next  = res_tstop_reg;
        m_valid_next    = m_valid_reg;
        out_load        = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = RAMP_NUMERATOR;
        div_req.divisor  = speed_inc;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_pw_next     = 1'b0;
                    res_pv_next     = '0;
                    res_tstart_next = 1'b0;
                    res_tstop_next  = 1'b0;
                    state_next      = ST_DONE;
                    case (s_kind)
                        KIND_TICK: begin
                            if (phase_reg == PH_ACCEL) begin
                                speed_next      = speed_inc;
                                res_pw_next     = 1'b1;
                                div_req.start   = 1'b1;
                                div_req.divisor = speed_inc;
                                op_next         = OP_ACCEL;
                                state_next      = ST_DIV;
                            end else if (phase_reg == PH_DECEL) begin
                                if (speed_reg > SPEED_STEP) begin
                                    speed_next      = speed_dec;
                                    res_pw_next     = 1'b1;
                                    div_req.start   = 1'b1;
                                    div_req.divisor = speed_dec;
                                    op_next         = OP_DECEL;
                                    state_next      = ST_DIV;
                                end else begin
                                    res_tstop_next = 1'b1;
                                end
                            end
                        end
                        KIND_STEP: begin
                            position_next  = pos_stepped;
                            res_tstop_next = goto_mode_reg
                                          && (pos_stepped == goal_position_reg);
                        end
                        KIND_START: begin
                            if (!(goto_mode_reg && (goal_position_reg == position_reg))) begin
                                cruise_next     = cruise_full;
                                speed_next      = SPEED_STEP;
                                phase_next      = PH_ACCEL;
                                res_pw_next     = 1'b1;
                                res_pv_next     = RAMP_NUMERATOR;
                                res_tstart_next = 1'b1;
                                if (fast_speed_reg && (fast_divisor_reg != '0)
                                    && (cruise_full >= PERIOD_W'(fast_divisor_reg))) begin
                                    div_req.start    = 1'b1;
                                    div_req.dividend = cruise_full;
                                    div_req.divisor  = SPEED_W'(fast_divisor_reg);
                                    op_next          = OP_CRUISE;
                                    state_next       = ST_DIV;
                                end
                            end
                        end
                        KIND_STOP: begin
                            phase_next = PH_DECEL;
                        end
                        KIND_TSTOPPED: begin
                            phase_next = PH_IDLE;
                        end
                        KIND_LOAD: begin
                            position_next = s_load_value;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_DONE;
                    case (op_reg)
                        OP_ACCEL: begin
                            if (div_rsp.quotient <= cruise_reg) begin
                                res_pv_next = cruise_reg;
                                phase_next  = PH_CRUISE;
                            end else begin
                                res_pv_next = div_rsp.quotient;
                            end
                        end
                        OP_DECEL: begin
                            res_pv_next = div_rsp.quotient;
                        end
                        OP_CRUISE: begin
                            cruise_next = div_rsp.quotient;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            op_reg       <= OP_ACCEL;
            phase_reg    <= PH_IDLE;
            speed_reg    <= '0;
            cruise_reg   <= '0;
            position_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            phase_reg    <= phase_next;
            speed_reg    <= speed_next;
            cruise_reg   <= cruise_next;
            position_reg <= position_next;
            m_valid_reg  <= m_valid_next;
        end
        res_pw_reg     <= res_pw_next;
        res_pv_reg     <= res_pv_next;
        res_tstart_reg <= res_tstart_next;
        res_tstop_reg  <= res_tstop_next;
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_period_write <= res_pw_reg;
            m_period_value <= res_pv_reg;
            m_timer_start  <= res_tstart_reg;
            m_timer_stop   <= res_tstop_reg;
            m_dir_level    <= reverse_dir_reg;
            m_busy_res     <= (phase_reg != PH_IDLE);
            m_position     <= position_reg;
            m_phase        <= phase_reg;
        end
    end

    assign m_valid = m_valid_reg;

    // The divider is only started from the idle state on an accepted request.
    a_div_start_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> accept)
        else $error("divider started without an accepted request");

    // An accepted request always moves the sequencer out of idle.
    a_leave_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_DIV || state_reg == ST_DONE))
        else $error("sequencer stayed idle after a request");

    // Acceleration ends by SPEED_LIMIT at the latest, so the speed never exceeds it.
    a_speed_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        speed_reg <= SPEED_LIMIT)
        else $error("ramp speed beyond its limit");

    // A finished division is only seen while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("division finished outside the divide state");

endmodule

`default_nettype wire
